// ===== rtl/cnv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cnv_pkg
// Constants and helpers for the card number validator: length limits,
// status and brand codes, ascii codes and the luhn digit arithmetic.
// ----------------------------------------------------------------------------
package cnv_pkg;

	localparam int CHAR_W   = 8;
	localparam int DIGIT_W  = 4;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;
	localparam int BRAND_W  = 3;

	localparam logic [COUNT_W-1:0] MIN_DIGITS = 5'd13;
	localparam logic [COUNT_W-1:0] MAX_DIGITS = 5'd19;
	localparam logic [COUNT_W-1:0] COUNT_SAT  = 5'd20;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_CHAR = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_LUHN = 2'd3;

	// brand codes
	localparam logic [BRAND_W-1:0] BR_VISA   = 3'd0;
	localparam logic [BRAND_W-1:0] BR_MASTER = 3'd1;
	localparam logic [BRAND_W-1:0] BR_MAESTR = 3'd2;
	localparam logic [BRAND_W-1:0] BR_JCB    = 3'd3;
	localparam logic [BRAND_W-1:0] BR_AMEX   = 3'd4;
	localparam logic [BRAND_W-1:0] BR_OTHER  = 3'd5;

	// ascii codes
	localparam logic [CHAR_W-1:0] ASC_0     = 8'h30;
	localparam logic [CHAR_W-1:0] ASC_9     = 8'h39;
	localparam logic [CHAR_W-1:0] ASC_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] ASC_CR    = 8'h0d;
	localparam logic [CHAR_W-1:0] ASC_SPACE = 8'h20;

	// digit values that pick a brand
	localparam logic [DIGIT_W-1:0] DIG_3 = 4'd3;
	localparam logic [DIGIT_W-1:0] DIG_4 = 4'd4;
	localparam logic [DIGIT_W-1:0] DIG_5 = 4'd5;
	localparam logic [DIGIT_W-1:0] DIG_6 = 4'd6;
	localparam logic [DIGIT_W-1:0] DIG_7 = 4'd7;

	// add two values below ten, modulo ten
	function automatic logic [DIGIT_W-1:0] add_mod10(input logic [DIGIT_W-1:0] a,
			input logic [DIGIT_W-1:0] b);
		logic [DIGIT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 5'd10) begin
			s = s - 5'd10;
		end
		return s[DIGIT_W-1:0];
	endfunction

	// doubled digit with its two decimal digits summed
	function automatic logic [DIGIT_W-1:0] luhn_double(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W:0] dd;
		dd = {d, 1'b0};
		if (dd > 5'd9) begin
			dd = dd - 5'd9;
		end
		return dd[DIGIT_W-1:0];
	endfunction

	// brand from the first two digits
	function automatic logic [BRAND_W-1:0] pick_brand(input logic [DIGIT_W-1:0] d0,
			input logic [DIGIT_W-1:0] d1);
		logic [BRAND_W-1:0] b;
		case (d0)
			DIG_3:   b = (d1 == DIG_4 || d1 == DIG_7) ? BR_AMEX : BR_JCB;
			DIG_4:   b = BR_VISA;
			DIG_5:   b = BR_MASTER;
			DIG_6:   b = BR_MAESTR;
			default: b = BR_OTHER;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/card_number_validator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// card_number_validator_core
// Luhn mod-10 card number check over a stream of ascii characters, with
// length check, bad-character detection and brand from the leading digits.
// ----------------------------------------------------------------------------
// path: the result of a last beat reaches m_tvalid through the input register,
//   then the result register
// throughput: one character per cycle; a last beat waits in the input register
//   only while the previous result is still held on the output
// reset: arst_n clears all valid flags, counters, sums and kept digits
module card_number_validator_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] character
	input  wire         s_tlast,   // is_last
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata    // [1:0] status, [4:2] brand, [9:5] digit_count, rest 0
);

	localparam int CW = cnv_pkg::CHAR_W;
	localparam int DW = cnv_pkg::DIGIT_W;
	localparam int NW = cnv_pkg::COUNT_W;
	localparam int SW = cnv_pkg::STATUS_W;
	localparam int BW = cnv_pkg::BRAND_W;

	// input register
	logic          valid_s1;
	logic [CW-1:0] char_s1;
	logic          last_s1;
	logic          adv;

	// running state
	logic [NW-1:0] count_q;
	logic [DW-1:0] sum_u_q, sum_d_q, dig0_q, dig1_q;
	logic          bad_q;

	// next state
	logic [NW-1:0] count_n;
	logic [DW-1:0] sum_u_n, sum_d_n, dig0_n, dig1_n;
	logic          bad_n;

	logic          is_space, is_digit;
	logic [CW-1:0] diff;
	logic [DW-1:0] d, dd, sum_sel;
	logic [SW-1:0] status;
	logic [BW-1:0] brand;

	// result register
	logic [SW-1:0] status_q;
	logic [BW-1:0] brand_q;
	logic [NW-1:0] cnt_out_q;

	// s1 moves on unless it is a last beat and the result register is held
	assign adv      = valid_s1 && (!last_s1 || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// classify the character
	assign is_space = (char_s1 >= cnv_pkg::ASC_TAB && char_s1 <= cnv_pkg::ASC_CR) ||
			char_s1 == cnv_pkg::ASC_SPACE;
	assign is_digit = char_s1 >= cnv_pkg::ASC_0 && char_s1 <= cnv_pkg::ASC_9;
	assign diff     = char_s1 - cnv_pkg::ASC_0;
	assign d        = diff[DW-1:0];
	assign dd       = cnv_pkg::luhn_double(d);

	// state update for one character
	always_comb begin
		count_n = count_q;
		sum_u_n = sum_u_q;
		sum_d_n = sum_d_q;
		dig0_n  = dig0_q;
		dig1_n  = dig1_q;
		bad_n   = bad_q;
		if (!is_space) begin
			if (is_digit) begin
				if (count_q < cnv_pkg::COUNT_SAT) begin
					if (!count_q[0]) begin
						sum_u_n = cnv_pkg::add_mod10(sum_u_q, d);
						sum_d_n = cnv_pkg::add_mod10(sum_d_q, dd);
					end else begin
						sum_u_n = cnv_pkg::add_mod10(sum_u_q, dd);
						sum_d_n = cnv_pkg::add_mod10(sum_d_q, d);
					end
					if (count_q == '0) begin
						dig0_n = d;
					end
					if (count_q == NW'(1)) begin
						dig1_n = d;
					end
					count_n = count_q + NW'(1);
				end
			end else begin
				bad_n = 1'b1;
			end
		end
	end

	// final status from the updated state
	assign sum_sel = count_n[0] ? sum_u_n : sum_d_n;
	assign brand   = cnv_pkg::pick_brand(dig0_n, dig1_n);

	always_comb begin
		if (bad_n) begin
			status = cnv_pkg::ST_BAD_CHAR;
		end else if (count_n < cnv_pkg::MIN_DIGITS || count_n > cnv_pkg::MAX_DIGITS) begin
			status = cnv_pkg::ST_BAD_LEN;
		end else if (sum_sel != '0) begin
			status = cnv_pkg::ST_BAD_LUHN;
		end else begin
			status = cnv_pkg::ST_OK;
		end
	end

	// running state, cleared after the last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_u_q <= '0;
			sum_d_q <= '0;
			dig0_q  <= '0;
			dig1_q  <= '0;
			bad_q   <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				count_q <= '0;
				sum_u_q <= '0;
				sum_d_q <= '0;
				dig0_q  <= '0;
				dig1_q  <= '0;
				bad_q   <= 1'b0;
			end else begin
				count_q <= count_n;
				sum_u_q <= sum_u_n;
				sum_d_q <= sum_d_n;
				dig0_q  <= dig0_n;
				dig1_q  <= dig1_n;
				bad_q   <= bad_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv && last_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			status_q  <= status;
			brand_q   <= brand;
			cnt_out_q <= count_n;
		end
	end

	assign m_tdata = {6'd0, cnt_out_q, brand_q, status_q};

endmodule
`default_nettype wire

// ===== bench/tb_card_number_validator_core.sv =====
// ----------------------------------------------------------------------------
// tb_card_number_validator_core
// Self-checking bench for the card number validator. Card number text is
// streamed one character per beat; a local model follows the digit count,
// both luhn parity sums, the bad-character mark and the leading digits, and
// queues the verdict for every beat flagged last. Verdicts from the block
// are compared field by field in arrival order, under random idling on
// both sides, a long output stall and a full drain between phases.
// ----------------------------------------------------------------------------
module tb_card_number_validator_core;

	// verdict fields, status in the lowest bits as on m_tdata
	typedef struct packed {
		logic [cnv_pkg::COUNT_W-1:0]  count;
		logic [cnv_pkg::BRAND_W-1:0]  brand;
		logic [cnv_pkg::STATUS_W-1:0] status;
	} card_verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] character
	logic        s_tlast = 1'b0; // is_last
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [1:0] status, [4:2] brand, [9:5] digit_count

	// model state of the card being read
	logic [cnv_pkg::COUNT_W-1:0] seen_digits = '0;
	logic [cnv_pkg::DIGIT_W-1:0] sum_len_odd = '0;
	logic [cnv_pkg::DIGIT_W-1:0] sum_len_even = '0;
	logic                        junk_seen = 1'b0;
	logic [cnv_pkg::DIGIT_W-1:0] lead_digit = '0;
	logic [cnv_pkg::DIGIT_W-1:0] next_digit = '0;

	card_verdict_t verdicts_due[$];
	logic [7:0]    line_buf[$];

	int fail_count = 0;
	int chars_sent = 0;
	int rx_hold_left = 0;
	bit tx_gaps_on = 1'b1;
	bit rx_idle_on = 1'b1;

	card_number_validator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// run limit
	initial begin
		#3_000_000;
		$display("FAILURE");
		$finish;
	end

	// model: fold one accepted character into the card state
	task automatic absorb_char(input logic [7:0] c, input bit last);
		logic [cnv_pkg::DIGIT_W-1:0] d;
		logic [cnv_pkg::DIGIT_W-1:0] dd;
		logic [cnv_pkg::DIGIT_W-1:0] sum;
		card_verdict_t               v;
		int                          t;
		if (!((c >= cnv_pkg::ASC_TAB && c <= cnv_pkg::ASC_CR) || c == cnv_pkg::ASC_SPACE)) begin
			if (c >= cnv_pkg::ASC_0 && c <= cnv_pkg::ASC_9) begin
				if (seen_digits < cnv_pkg::COUNT_SAT) begin
					d  = cnv_pkg::DIGIT_W'(c - cnv_pkg::ASC_0);
					t  = 2 * int'(d);
					dd = cnv_pkg::DIGIT_W'(t > 9 ? t - 9 : t);
					// even index adds plain to the odd-length sum, doubled to the other
					if (!seen_digits[0]) begin
						sum_len_odd  = cnv_pkg::DIGIT_W'((int'(sum_len_odd) + int'(d)) % 10);
						sum_len_even = cnv_pkg::DIGIT_W'((int'(sum_len_even) + int'(dd)) % 10);
					end else begin
						sum_len_odd  = cnv_pkg::DIGIT_W'((int'(sum_len_odd) + int'(dd)) % 10);
						sum_len_even = cnv_pkg::DIGIT_W'((int'(sum_len_even) + int'(d)) % 10);
					end
					if (seen_digits == 0) lead_digit = d;
					else if (seen_digits == 1) next_digit = d;
					seen_digits = seen_digits + 1'b1;
				end
			end else begin
				junk_seen = 1'b1;
			end
		end
		if (!last) return;

		sum = seen_digits[0] ? sum_len_odd : sum_len_even;
		if (junk_seen) v.status = cnv_pkg::ST_BAD_CHAR;
		else if (seen_digits < cnv_pkg::MIN_DIGITS || seen_digits > cnv_pkg::MAX_DIGITS)
			v.status = cnv_pkg::ST_BAD_LEN;
		else if (sum != 0) v.status = cnv_pkg::ST_BAD_LUHN;
		else v.status = cnv_pkg::ST_OK;
		case (lead_digit)
			cnv_pkg::DIG_3: v.brand = (next_digit == cnv_pkg::DIG_4 || next_digit == cnv_pkg::DIG_7) ?
					cnv_pkg::BR_AMEX : cnv_pkg::BR_JCB;
			cnv_pkg::DIG_4: v.brand = cnv_pkg::BR_VISA;
			cnv_pkg::DIG_5: v.brand = cnv_pkg::BR_MASTER;
			cnv_pkg::DIG_6: v.brand = cnv_pkg::BR_MAESTR;
			default: v.brand = cnv_pkg::BR_OTHER;
		endcase
		v.count = seen_digits;
		verdicts_due.push_back(v);

		seen_digits  = '0;
		sum_len_odd  = '0;
		sum_len_even = '0;
		junk_seen    = 1'b0;
		lead_digit   = '0;
		next_digit   = '0;
	endtask

	task automatic note_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// result checker: one verdict per output beat, oldest first
	always @(posedge clk) begin : check_results
		card_verdict_t want;
		card_verdict_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = card_verdict_t'(m_tdata[$bits(card_verdict_t)-1:0]);
			if (verdicts_due.size() == 0) begin
				note_mismatch($sformatf("result with none expected, m_tdata %h", m_tdata));
			end else begin
				want = verdicts_due.pop_front();
				if (got.status !== want.status)
					note_mismatch($sformatf("status exp %0d got %0d", want.status, got.status));
				if (got.brand !== want.brand)
					note_mismatch($sformatf("brand exp %0d got %0d", want.brand, got.brand));
				if (got.count !== want.count)
					note_mismatch($sformatf("digit count exp %0d got %0d", want.count, got.count));
				if (m_tdata[15:$bits(card_verdict_t)] !== '0)
					note_mismatch($sformatf("padding bits not zero, m_tdata %h", m_tdata));
			end
		end
	end

	// output side: random stall bursts, plus a long hold on request
	initial begin : rx_side
		int stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold_left > 0) begin
				m_tready <= 1'b0;
				rx_hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(0, 9);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// one input beat, with an optional idle burst ahead of it
	task automatic send_char(input logic [7:0] c, input bit last);
		if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		absorb_char(c, last);
		chars_sent++;
	endtask

	task automatic send_line();
		if (line_buf.size() == 0) line_buf.push_back(cnv_pkg::ASC_SPACE);
		foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
		line_buf.delete();
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (verdicts_due.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_blank();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? cnv_pkg::ASC_SPACE : cnv_pkg::ASC_TAB + 8'(r);
	endfunction

	function automatic logic [7:0] pick_junk();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while ((c >= cnv_pkg::ASC_0 && c <= cnv_pkg::ASC_9) ||
			(c >= cnv_pkg::ASC_TAB && c <= cnv_pkg::ASC_CR) || c == cnv_pkg::ASC_SPACE);
		return c;
	endfunction

	// build a card number text in line_buf; d0/d1 below zero pick at random
	task automatic make_card(input int n_dig, input int d0, input int d1, input bit good,
			input int sep_pct);
		int dg[32];
		int acc;
		int place;
		int dbl;
		for (int i = 0; i < 32; i++) dg[i] = $urandom_range(0, 9);
		if (d0 >= 0) dg[0] = d0;
		else if ($urandom_range(0, 1))
			dg[0] = $urandom_range(int'(cnv_pkg::DIG_3), int'(cnv_pkg::DIG_6));
		if (d1 >= 0) dg[1] = d1;
		else if ($urandom_range(0, 3) == 0)
			dg[1] = $urandom_range(0, 1) ? int'(cnv_pkg::DIG_4) : int'(cnv_pkg::DIG_7);
		// check digit in the last place, wrong on purpose when not good
		if (n_dig > 0) begin
			acc = 0;
			for (int i = 0; i < n_dig - 1; i++) begin
				place = n_dig - 1 - i;
				dbl   = 2 * dg[i];
				acc  += (place % 2 == 1) ? (dbl > 9 ? dbl - 9 : dbl) : dg[i];
			end
			dg[n_dig-1] = (10 - acc % 10) % 10;
			if (!good) dg[n_dig-1] = (dg[n_dig-1] + $urandom_range(1, 9)) % 10;
		end
		for (int i = 0; i < n_dig; i++) begin
			if ($urandom_range(0, 99) < sep_pct) line_buf.push_back(pick_blank());
			line_buf.push_back(cnv_pkg::ASC_0 + 8'(dg[i]));
		end
	endtask

	// lone characters, whitespace and bad characters on the last beat
	task automatic test_edge_chars();
		line_buf.push_back(cnv_pkg::ASC_SPACE);
		send_line();
		line_buf.push_back(cnv_pkg::ASC_0 + 8'(cnv_pkg::DIG_3));
		send_line();
		line_buf.push_back(8'h00);
		send_line();
		line_buf.push_back(8'hff);
		send_line();
		for (int i = 0; i <= int'(cnv_pkg::ASC_CR - cnv_pkg::ASC_TAB); i++)
			line_buf.push_back(cnv_pkg::ASC_TAB + 8'(i));
		line_buf.push_back(cnv_pkg::ASC_0 + 8'(cnv_pkg::DIG_6));
		line_buf.push_back(cnv_pkg::ASC_SPACE);
		send_line();
		line_buf.push_back(cnv_pkg::ASC_0 + 8'(cnv_pkg::DIG_5));
		line_buf.push_back(8'h80);
		line_buf.push_back(cnv_pkg::ASC_0 + 8'd1);
		send_line();
		line_buf.push_back(cnv_pkg::ASC_0 + 8'(cnv_pkg::DIG_7));
		line_buf.push_back(cnv_pkg::ASC_0 - 8'd1);
		line_buf.push_back(cnv_pkg::ASC_9 + 8'd1);
		send_line();
	endtask

	// every brand, both length limits, luhn failures and saturation
	task automatic test_card_lengths();
		make_card(13, int'(cnv_pkg::DIG_4), -1, 1'b1, 0); send_line();
		make_card(19, int'(cnv_pkg::DIG_3), int'(cnv_pkg::DIG_7), 1'b1, 20); send_line();
		make_card(16, int'(cnv_pkg::DIG_3), int'(cnv_pkg::DIG_4), 1'b0, 0); send_line();
		make_card(15, int'(cnv_pkg::DIG_3), int'(cnv_pkg::DIG_5), 1'b1, 0); send_line();
		make_card(16, int'(cnv_pkg::DIG_5), -1, 1'b1, 0); send_line();
		make_card(18, int'(cnv_pkg::DIG_6), -1, 1'b0, 0); send_line();
		make_card(14, 9, 9, 1'b1, 0);                     send_line();
		make_card(12, int'(cnv_pkg::DIG_4), -1, 1'b1, 0); send_line();
		make_card(20, int'(cnv_pkg::DIG_5), -1, 1'b1, 0); send_line();
		make_card(23, 0, 0, 1'b1, 10);                    send_line();
		make_card(2, int'(cnv_pkg::DIG_3), int'(cnv_pkg::DIG_4), 1'b1, 0); send_line();
		wait_drained();
	endtask

	// long output stall while the input keeps offering back to back
	task automatic test_backpressure();
		tx_gaps_on   = 1'b0;
		rx_hold_left = 150;
		for (int i = 0; i < 5; i++) begin
			make_card($urandom_range(13, 19), -1, -1, $urandom_range(0, 3) != 0, 0);
			send_line();
		end
		wait_drained();
		tx_gaps_on = 1'b1;
	endtask

	// mostly well-formed cards, some broken ones and raw noise
	task automatic test_random_mix();
		int first_char;
		int lines;
		int kind;
		first_char = chars_sent;
		lines      = 0;
		while (chars_sent - first_char < 330 || lines < 20) begin
			if (lines % 8 == 0) begin
				tx_gaps_on = $urandom_range(0, 2) != 0;
				rx_idle_on = $urandom_range(0, 2) != 0;
			end
			if (lines == 10) wait_drained();
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				make_card($urandom_range(13, 19), -1, -1, $urandom_range(0, 3) != 0,
					$urandom_range(0, 1) ? 10 : 0);
			end else if (kind < 75) begin
				make_card($urandom_range(0, 24), -1, -1, $urandom_range(0, 1), 5);
			end else if (kind < 85) begin
				make_card($urandom_range(13, 19), -1, -1, 1'b1, 0);
				line_buf.insert($urandom_range(0, line_buf.size()), pick_junk());
			end else if (kind < 93) begin
				make_card($urandom_range(12, 20), -1, -1, $urandom_range(0, 1), 0);
				line_buf.push_back($urandom_range(0, 1) ? pick_blank() : pick_junk());
			end else begin
				repeat ($urandom_range(1, 30)) line_buf.push_back(8'($urandom_range(0, 255)));
			end
			send_line();
			lines++;
		end
	endtask

	// closing stretch at full rate on both sides
	task automatic test_quiet_tail();
		tx_gaps_on = 1'b0;
		rx_idle_on = 1'b0;
		for (int i = 0; i < 12; i++) begin
			make_card($urandom_range(13, 19), -1, -1, $urandom_range(0, 3) != 0, 0);
			send_line();
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_chars();
		test_card_lengths();
		test_backpressure();
		test_random_mix();
		test_quiet_tail();
		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && verdicts_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
